/* hw/rtl/pde_pkg.sv */
package pde_pkg;

    // Data widths fixed by the transaction fields
    localparam int COEF_W = 32;
    localparam int VAL_W  = 64;
    localparam int DER_W  = 4;
    localparam int ORD_W  = 3;
    // Falling factorial n!/(n-r)! for n up to 15 fits in 41 bits
    localparam int FF_W   = 41;
    localparam int PRD_W  = 96;

    // Micro-program step addresses
    typedef logic [2:0] t_step;
    localparam t_step STEP_CHK  = 3'd0;
    localparam t_step STEP_T_LO = 3'd1;
    localparam t_step STEP_T_HI = 3'd2;
    localparam t_step STEP_A_LO = 3'd3;
    localparam t_step STEP_A_HI = 3'd4;
    localparam t_step STEP_RND  = 3'd5;
    localparam t_step STEP_ADD  = 3'd6;
    localparam t_step STEP_DONE = 3'd7;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_TERM_LO,
        MUL_TERM_HI,
        MUL_ACC_LO,
        MUL_ACC_HI
    } t_mul;

    // Jump conditions
    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_IF_SKIP,
        JMP_IF_MORE
    } t_jmp;

    // One control word
    typedef struct packed {
        t_mul  mul;
        logic  term_ld;
        logic  rnd;
        logic  add;
        logic  done;
        t_jmp  jmp;
        t_step target;
    } t_ctrl;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic skip;   // derivative order above the effective order
        logic more;   // further coefficients remain in the walk
    } t_stat;

    localparam t_ctrl CTRL_NOP = '{
        mul: MUL_NONE, term_ld: 1'b0, rnd: 1'b0, add: 1'b0,
        done: 1'b0, jmp: JMP_NONE, target: STEP_CHK
    };

    // Micro-program: one Horner step is T_LO through ADD
    function automatic t_ctrl ucode(t_step step);
        t_ctrl c;
        c = CTRL_NOP;
        unique case (step)
            STEP_CHK: begin
                c.jmp    = JMP_IF_SKIP;
                c.target = STEP_DONE;
            end
            STEP_T_LO: c.mul = MUL_TERM_LO;
            STEP_T_HI: c.mul = MUL_TERM_HI;
            STEP_A_LO: begin
                c.mul     = MUL_ACC_LO;
                c.term_ld = 1'b1;
            end
            STEP_A_HI: c.mul = MUL_ACC_HI;
            STEP_RND:  c.rnd = 1'b1;
            STEP_ADD: begin
                c.add    = 1'b1;
                c.jmp    = JMP_IF_MORE;
                c.target = STEP_T_LO;
            end
            STEP_DONE: c.done = 1'b1;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/pde_sequencer.sv */
module pde_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_launch,
    input  pde_pkg::t_stat i_stat,
    output pde_pkg::t_ctrl o_ctrl,
    output logic           o_busy,
    output logic           o_done
);

    logic           r_busy;
    pde_pkg::t_step r_step;
    logic           n_busy;
    pde_pkg::t_step n_step;
    pde_pkg::t_ctrl word;
    logic           take;

    // Fetch the control word of the current step
    assign word   = pde_pkg::ucode(r_step);
    assign o_ctrl = r_busy ? word : pde_pkg::CTRL_NOP;
    assign o_busy = r_busy;
    assign o_done = r_busy && word.done;

    // Evaluate the jump condition
    always_comb begin
        unique case (word.jmp)
            pde_pkg::JMP_IF_SKIP: take = i_stat.skip;
            pde_pkg::JMP_IF_MORE: take = i_stat.more;
            default:              take = 1'b0;
        endcase
    end

    // Advance, jump or finish
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_launch) begin
                n_busy = 1'b1;
                n_step = pde_pkg::STEP_CHK;
            end
        end else if (word.done) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_step = word.target;
        end else begin
            n_step = r_step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= pde_pkg::STEP_CHK;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

endmodule

/* hw/rtl/pde_datapath.sv */
module pde_datapath #(
    parameter int MAX_ORDER = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_launch,
    input  logic                        i_load,
    input  logic [pde_pkg::ORD_W-1:0]   i_coeff_power,
    input  logic signed [pde_pkg::COEF_W-1:0] i_coeff_value,
    input  logic signed [pde_pkg::COEF_W-1:0] i_tau,
    input  logic [pde_pkg::DER_W-1:0]   i_deriv_order,
    input  logic [pde_pkg::ORD_W-1:0]   i_degree,
    input  pde_pkg::t_ctrl              i_ctrl,
    output pde_pkg::t_stat              o_stat,
    output logic signed [pde_pkg::VAL_W-1:0] o_value,
    output logic                        o_overflow
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAB_N = DEPTH * 16;
    localparam int TAB_W = IDX_W + pde_pkg::DER_W;
    localparam int CW    = pde_pkg::COEF_W;
    localparam int VW    = pde_pkg::VAL_W;
    localparam int PW    = pde_pkg::PRD_W;
    localparam int FW    = pde_pkg::FF_W;

    localparam logic [VW-1:0] NEG_LIM = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] POS_LIM = {1'b0, {(VW-1){1'b1}}};
    localparam logic [PW-1:0] RND_HALF = PW'(32'h8000);

    typedef logic [FW-1:0] t_ff_tab [TAB_N];

    typedef struct packed {
        logic [VW-1:0] val;
        logic          ovf;
    } t_sat;

    // Falling factorial table, entry n*16 + r
    function automatic t_ff_tab build_ff();
        t_ff_tab       tab;
        logic [FW-1:0] f;
        for (int n = 0; n < DEPTH; n++) begin
            for (int r = 0; r < 16; r++) begin
                f = FW'(1);
                for (int m = 0; m < r; m++) begin
                    if (n >= m) f = f * FW'(n - m);
                    else f = '0;
                end
                tab[n * 16 + r] = f;
            end
        end
        return tab;
    endfunction

    localparam t_ff_tab FF_TAB = build_ff();

    // Clamp a magnitude to the signed 64-bit range and apply the sign
    function automatic t_sat sat64(logic hi_nz, logic [VW-1:0] lo, logic neg);
        t_sat          s;
        logic [VW-1:0] limit;
        logic [VW-1:0] v;
        limit = neg ? NEG_LIM : POS_LIM;
        s.ovf = hi_nz || (lo > limit);
        v     = s.ovf ? limit : lo;
        s.val = neg ? (~v + VW'(1)) : v;
        return s;
    endfunction

    logic [CW-1:0]          r_store [DEPTH];
    logic [CW-1:0]          r_tau;
    logic [pde_pkg::DER_W-1:0] r_r;
    logic [IDX_W-1:0]       r_n;
    logic [VW-1:0]          r_acc;
    logic [VW-1:0]          r_tmp;
    logic [VW-1:0]          r_term;
    logic [PW-1:0]          r_prd;
    logic                   r_ovf;

    logic [IDX_W-1:0]       eff_k;
    logic [CW-1:0]          coef;
    logic [CW-1:0]          coef_mag;
    logic [CW-1:0]          tau_mag;
    logic [VW-1:0]          acc_mag;
    logic [FW-1:0]          ff;
    logic [TAB_W-1:0]       ff_idx;
    logic [CW-1:0]          mul_a;
    logic [CW-1:0]          mul_b;
    logic [2*CW-1:0]        prod;
    logic                   mul_hi;
    t_sat                   term_sat;
    t_sat                   rnd_sat;
    logic [PW-1:0]          rnd_sum;
    logic [VW-1:0]          add_sum;
    logic                   add_ovf;
    logic [VW-1:0]          add_res;

    // Effective order is the smaller of the degree register and MAX_ORDER
    assign eff_k = (int'(i_degree) < MAX_ORDER) ? IDX_W'(i_degree)
                                                : IDX_W'(MAX_ORDER);

    // Walk status
    assign o_stat.skip = (5'(r_r) > 5'(r_n));
    assign o_stat.more = (5'(r_n) != 5'(r_r));

    // Operand magnitudes
    assign coef     = r_store[r_n];
    assign coef_mag = coef[CW-1] ? (~coef + CW'(1)) : coef;
    assign tau_mag  = r_tau[CW-1] ? (~r_tau + CW'(1)) : r_tau;
    assign acc_mag  = r_acc[VW-1] ? (~r_acc + VW'(1)) : r_acc;
    assign ff_idx   = {r_n, r_r};
    assign ff       = FF_TAB[ff_idx];

    // Shared 32x32 multiplier, 64x32 products in two passes
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_hi = 1'b0;
        unique case (i_ctrl.mul)
            pde_pkg::MUL_TERM_LO: begin
                mul_a = ff[CW-1:0];
                mul_b = coef_mag;
            end
            pde_pkg::MUL_TERM_HI: begin
                mul_a  = {{(2*CW-FW){1'b0}}, ff[FW-1:CW]};
                mul_b  = coef_mag;
                mul_hi = 1'b1;
            end
            pde_pkg::MUL_ACC_LO: begin
                mul_a = acc_mag[CW-1:0];
                mul_b = tau_mag;
            end
            pde_pkg::MUL_ACC_HI: begin
                mul_a  = acc_mag[VW-1:CW];
                mul_b  = tau_mag;
                mul_hi = 1'b1;
            end
            default: ;
        endcase
    end

    assign prod = (2*CW)'(mul_a) * (2*CW)'(mul_b);

    // Term: coefficient times falling factorial, exact then clamped
    assign term_sat = sat64(|r_prd[PW-1:VW], r_prd[VW-1:0],
                            coef[CW-1] && (r_prd != '0));

    // Scaled accumulator: round to nearest, ties away, drop 16 fraction bits
    assign rnd_sum = r_prd + RND_HALF;
    assign rnd_sat = sat64(|rnd_sum[PW-1:VW+16], rnd_sum[VW+15:16],
                           r_acc[VW-1] ^ r_tau[CW-1]);

    // Saturating add of scaled accumulator and term
    assign add_sum = r_tmp + r_term;
    assign add_ovf = (r_tmp[VW-1] == r_term[VW-1]) && (add_sum[VW-1] != r_tmp[VW-1]);
    assign add_res = add_ovf ? (r_tmp[VW-1] ? NEG_LIM : POS_LIM) : add_sum;

    // Coefficient store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_store[i] <= '0;
        end else if (i_load && (int'(i_coeff_power) <= MAX_ORDER)) begin
            r_store[IDX_W'(i_coeff_power)] <= i_coeff_value;
        end
    end

    // Evaluation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else begin
            if (i_launch) begin
                r_ovf <= 1'b0;
            end else begin
                r_ovf <= r_ovf
                       | (i_ctrl.term_ld & term_sat.ovf)
                       | (i_ctrl.rnd & rnd_sat.ovf)
                       | (i_ctrl.add & add_ovf);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_launch) begin
            r_tau <= i_tau;
            r_r   <= i_deriv_order;
            r_n   <= eff_k;
            r_acc <= '0;
        end else begin
            if (i_ctrl.mul != pde_pkg::MUL_NONE) begin
                r_prd <= mul_hi ? (r_prd + {prod, {CW{1'b0}}})
                                : {{(PW-2*CW){1'b0}}, prod};
            end
            if (i_ctrl.term_ld) r_term <= term_sat.val;
            if (i_ctrl.rnd) r_tmp <= rnd_sat.val;
            if (i_ctrl.add) begin
                r_acc <= add_res;
                if (o_stat.more) r_n <= r_n - IDX_W'(1);
            end
        end
    end

    assign o_value    = r_acc;
    assign o_overflow = r_ovf;

endmodule

/* hw/rtl/polynomial_derivative_evaluator_unit.sv */
// Channel   Direction  Handshake                  Payload
// command   in         start, busy                i_func, i_coeff_power, i_coeff_value,
//                                                 i_tau, i_deriv_order
// result    out        o_strobe (one cycle)       o_value, o_overflow
// config    in         i_cfg_we                   i_cfg_wdata (polynomial degree)
//
// A load transaction writes the coefficient store and keeps busy low.
// An evaluation holds busy until its result is presented; it does one Horner step per
// power from K = min(degree, MAX_ORDER) down to r, none when r > K. Each step has six
// micro-steps on the one shared 32x32 multiplier (four passes, a rounding and an add).
// The result is presented with o_strobe in the last busy cycle; the receiver cannot stall.
// Synchronous active-low reset clears the coefficient store and sets the degree to 7.
module polynomial_derivative_evaluator_unit #(
    parameter int MAX_ORDER = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [pde_pkg::ORD_W-1:0]          i_coeff_power,
    input  logic signed [pde_pkg::COEF_W-1:0]  i_coeff_value,
    input  logic signed [pde_pkg::COEF_W-1:0]  i_tau,
    input  logic [pde_pkg::DER_W-1:0]          i_deriv_order,
    input  logic                               i_cfg_we,
    input  logic [pde_pkg::ORD_W-1:0]          i_cfg_wdata,
    output logic                               o_strobe,
    output logic signed [pde_pkg::VAL_W-1:0]   o_value,
    output logic                               o_overflow
);

    logic [pde_pkg::ORD_W-1:0] r_degree;
    logic                      accept;
    logic                      launch;
    logic                      load;
    pde_pkg::t_ctrl            ctrl;
    pde_pkg::t_stat            stat;

    // Decode the accepted transaction
    assign accept = start && !busy;
    assign launch = accept && i_func;
    assign load   = accept && !i_func;

    // Hold the polynomial degree register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd7;
        end else if (i_cfg_we) begin
            r_degree <= i_cfg_wdata;
        end
    end

    pde_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_launch(launch),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy),
        .o_done  (o_strobe)
    );

    pde_datapath #(
        .MAX_ORDER(MAX_ORDER)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_launch     (launch),
        .i_load       (load),
        .i_coeff_power(i_coeff_power),
        .i_coeff_value(i_coeff_value),
        .i_tau        (i_tau),
        .i_deriv_order(i_deriv_order),
        .i_degree     (r_degree),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .o_value      (o_value),
        .o_overflow   (o_overflow)
    );

endmodule
